@@ hdl/ptb_pkg.sv @@
package ptb_pkg;

	localparam int MAX_LEN_DEF  = 4096;
	localparam int ALPHABET_DEF = 26;
	localparam int LETTER_W     = 5;
	localparam int OUT_W        = 13;
	localparam int ROOT_EVEN    = 0;
	localparam int ROOT_ODD     = 1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NODE_RD,
		ST_NODE_CHK,
		ST_TEXT_CHK,
		ST_CHILD_RD,
		ST_CHILD_CHK,
		ST_INFO_RD,
		ST_INFO_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OUT_W-1:0] node_index;
		logic [OUT_W-1:0] pal_length;
		logic [OUT_W-1:0] suffix_pal_count;
		logic             created;
		logic             overflow;
	} result_t;

endpackage

@@ hdl/ptb_if.sv @@
interface ptb_letter_if;
	import ptb_pkg::*;

	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] letter;

	modport source (output valid, output letter, input ready);
	modport sink (input valid, input letter, output ready);
endinterface

interface ptb_result_if;
	import ptb_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] node_index;
	logic [OUT_W-1:0] pal_length;
	logic [OUT_W-1:0] suffix_pal_count;
	logic             created;
	logic             overflow;

	modport source (output valid, output node_index, output pal_length,
		output suffix_pal_count, output created, output overflow, input ready);
	modport sink (input valid, input node_index, input pal_length,
		input suffix_pal_count, input created, input overflow, output ready);
endinterface

@@ hdl/palindrome_tree_builder_core.sv @@
// Palindromic tree builder.
// letters: one letter per item (0..ALPHABET-1, larger codes saturate to the
// last letter). results: one item per letter with the node of the longest
// palindromic suffix, its length, the number of palindromic suffixes ending
// there, a created flag and an overflow flag.
// Both channels use valid/ready; an item moves when both are high.
// One letter is worked at a time. After acceptance the core walks the
// suffix-link chain: each node visited takes one node memory read, then one
// text memory read, and the text read is skipped when the length alone rules
// it out or the node is the odd root. It then reads the child table and the
// node memory for the result. A new node adds a second walk over the chain
// for its suffix link. Link steps are amortized constant per letter. The
// next letter is taken in the cycle after the result is loaded. After
// MAX_LEN letters every further letter returns overflow = 1 with zero
// fields.
// Reset: the child table is cleared one entry per cycle, all NODE_CAP*ALPHABET
// entries (106548 at the default size), with letters.ready low.
// The result sits in an output register; while results.ready is low the
// next letter is still taken and worked, and it waits for the register.
module palindrome_tree_builder_core #(
	parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
	parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ptb_letter_if.sink   letters,
	ptb_result_if.source results
);
	import ptb_pkg::*;

	localparam int NODE_CAP = MAX_LEN + 2;
	localparam int PW       = $clog2(MAX_LEN + 1);
	localparam int NW       = $clog2(NODE_CAP);
	localparam int TAW      = $clog2(MAX_LEN);
	localparam int CDEPTH   = NODE_CAP * ALPHABET;
	localparam int CAW      = $clog2(CDEPTH);
	localparam int NDW      = NW + 2 * PW;

	logic                idle;
	logic                fin;
	logic                slot_free;
	logic                out_load;
	result_t             res;
	result_t             out_q;
	logic                out_vld_q;

	logic                text_we;
	logic [TAW-1:0]      text_waddr;
	logic [LETTER_W-1:0] text_wdata;
	logic [TAW-1:0]      text_raddr;
	logic [LETTER_W-1:0] text_rdata;
	logic                node_we;
	logic [NW-1:0]       node_waddr;
	logic [NDW-1:0]      node_wdata;
	logic [NW-1:0]       node_raddr;
	logic [NDW-1:0]      node_rdata;
	logic                child_we;
	logic [CAW-1:0]      child_waddr;
	logic [NW-1:0]       child_wdata;
	logic [CAW-1:0]      child_raddr;
	logic [NW-1:0]       child_rdata;

	ptb_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_LEN)) u_text_ram (
		.clk   (clk),
		.we    (text_we),
		.waddr (text_waddr),
		.wdata (text_wdata),
		.raddr (text_raddr),
		.rdata (text_rdata)
	);

	ptb_ram #(.WIDTH(NDW), .DEPTH(NODE_CAP)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	ptb_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child_ram (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.raddr (child_raddr),
		.rdata (child_rdata)
	);

	ptb_seq #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (letters.valid),
		.in_letter   (letters.letter),
		.idle        (idle),
		.fin         (fin),
		.slot_free   (slot_free),
		.res         (res),
		.text_we     (text_we),
		.text_waddr  (text_waddr),
		.text_wdata  (text_wdata),
		.text_raddr  (text_raddr),
		.text_rdata  (text_rdata),
		.node_we     (node_we),
		.node_waddr  (node_waddr),
		.node_wdata  (node_wdata),
		.node_raddr  (node_raddr),
		.node_rdata  (node_rdata),
		.child_we    (child_we),
		.child_waddr (child_waddr),
		.child_wdata (child_wdata),
		.child_raddr (child_raddr),
		.child_rdata (child_rdata)
	);

	assign letters.ready = idle;
	assign slot_free     = !out_vld_q || results.ready;
	assign out_load      = fin && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign results.valid            = out_vld_q;
	assign results.node_index       = out_q.node_index;
	assign results.pal_length       = out_q.pal_length;
	assign results.suffix_pal_count = out_q.suffix_pal_count;
	assign results.created          = out_q.created;
	assign results.overflow         = out_q.overflow;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		letters.valid && letters.ready |=> !letters.ready)
		else $error("letter taken while another is in flight");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		fin && !slot_free |=> fin)
		else $error("finished result dropped before output register was free");

	a_created_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res.created |-> res.pal_length != '0 && res.suffix_pal_count != '0)
		else $error("new node with zero length or count");

	a_overflow_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res.overflow |-> res.node_index == '0 && !res.created)
		else $error("overflow result carries node data");

endmodule

@@ hdl/ptb_ram.sv @@
module ptb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/ptb_seq.sv @@
module ptb_seq #(
	parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
	parameter int ALPHABET = ptb_pkg::ALPHABET_DEF,
	localparam int NODE_CAP = MAX_LEN + 2,
	localparam int PW       = $clog2(MAX_LEN + 1),
	localparam int NW       = $clog2(NODE_CAP),
	localparam int TAW      = $clog2(MAX_LEN),
	localparam int CDEPTH   = NODE_CAP * ALPHABET,
	localparam int CAW      = $clog2(CDEPTH),
	localparam int NDW      = NW + 2 * PW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ptb_pkg::LETTER_W-1:0]  in_letter,
	output logic                          idle,
	output logic                          fin,
	input  logic                          slot_free,
	output ptb_pkg::result_t              res,
	output logic                          text_we,
	output logic [TAW-1:0]                text_waddr,
	output logic [ptb_pkg::LETTER_W-1:0]  text_wdata,
	output logic [TAW-1:0]                text_raddr,
	input  logic [ptb_pkg::LETTER_W-1:0]  text_rdata,
	output logic                          node_we,
	output logic [NW-1:0]                 node_waddr,
	output logic [NDW-1:0]                node_wdata,
	output logic [NW-1:0]                 node_raddr,
	input  logic [NDW-1:0]                node_rdata,
	output logic                          child_we,
	output logic [CAW-1:0]                child_waddr,
	output logic [NW-1:0]                 child_wdata,
	output logic [CAW-1:0]                child_raddr,
	input  logic [NW-1:0]                 child_rdata
);
	import ptb_pkg::*;

	state_t state_q, state_d;

	logic [CAW-1:0]      clr_q;
	logic [PW-1:0]       pos_q;
	logic [NW-1:0]       total_q;
	logic [NW-1:0]       last_q;
	logic                phase_q;
	logic [LETTER_W-1:0] ch_q;
	logic [NW-1:0]       u_q;
	logic [NW-1:0]       link_q;
	logic [PW:0]         ulen_q;
	logic [PW:0]         plen_q;
	logic [CAW-1:0]      pcaddr_q;
	logic [NW-1:0]       tgt_q;
	result_t             res_q;

	logic [LETTER_W-1:0] ch_sat;
	logic                full;
	logic [NW-1:0]       nd_link;
	logic [PW-1:0]       nd_len;
	logic [PW-1:0]       nd_cnt;
	logic [NW-1:0]       cl;
	logic [PW:0]         clen;
	logic [PW+1:0]       k;
	logic                u_odd;
	logic                k_neg;
	logic                text_hit;
	logic                child_zero;
	logic [CAW-1:0]      caddr;
	logic [NW-1:0]       new_idx;
	logic [PW:0]         new_len_w;
	logic [PW-1:0]       new_cnt;

	assign ch_sat = (9'(in_letter) >= 9'(ALPHABET)) ? LETTER_W'(ALPHABET - 1) : in_letter;
	assign full   = (pos_q == PW'(MAX_LEN));

	assign nd_link = node_rdata[NDW-1 -: NW];
	assign nd_len  = node_rdata[2*PW-1 -: PW];
	assign nd_cnt  = node_rdata[PW-1:0];

	// roots are not kept in the node memory
	always_comb begin
		if (u_q == NW'(ROOT_EVEN)) begin
			cl   = NW'(ROOT_ODD);
			clen = '0;
		end else if (u_q == NW'(ROOT_ODD)) begin
			cl   = NW'(ROOT_EVEN);
			clen = '1;
		end else begin
			cl   = nd_link;
			clen = {1'b0, nd_len};
		end
	end

	assign k          = {2'b00, pos_q} - {clen[PW], clen} - (PW+2)'(1);
	assign u_odd      = (u_q == NW'(ROOT_ODD));
	assign k_neg      = k[PW+1];
	assign text_hit   = (text_rdata == ch_q);
	assign child_zero = (child_rdata == '0);
	assign caddr      = CAW'(u_q) * CAW'(ALPHABET) + CAW'(ch_q);
	assign new_idx    = total_q + NW'(1);
	assign new_len_w  = plen_q + (PW+1)'(2);
	assign new_cnt    = ((tgt_q < NW'(2)) ? PW'(0) : nd_cnt) + PW'(1);

	assign idle = (state_q == ST_IDLE);
	assign fin  = (state_q == ST_DONE);
	assign res  = res_q;

	assign text_we    = idle && in_valid && !full;
	assign text_waddr = pos_q[TAW-1:0];
	assign text_wdata = ch_sat;
	assign text_raddr = k[TAW-1:0];

	assign node_we    = (state_q == ST_INFO_CHK) && phase_q;
	assign node_waddr = new_idx;
	assign node_wdata = {tgt_q, new_len_w[PW-1:0], new_cnt};
	assign node_raddr = (state_q == ST_INFO_RD) ? tgt_q : u_q;

	assign child_raddr = caddr;

	always_comb begin
		child_we    = 1'b0;
		child_waddr = pcaddr_q;
		child_wdata = new_idx;
		if (state_q == ST_CLEAR) begin
			child_we    = 1'b1;
			child_waddr = clr_q;
			child_wdata = '0;
		end else if (state_q == ST_INFO_CHK && phase_q) begin
			child_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CAW'(CDEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = full ? ST_DONE : ST_NODE_RD;
				end
			end
			ST_NODE_RD:  state_d = ST_NODE_CHK;
			ST_NODE_CHK: begin
				if (u_odd) begin
					state_d = ST_CHILD_RD;
				end else if (k_neg) begin
					state_d = ST_NODE_RD;
				end else begin
					state_d = ST_TEXT_CHK;
				end
			end
			ST_TEXT_CHK: state_d = text_hit ? ST_CHILD_RD : ST_NODE_RD;
			ST_CHILD_RD: state_d = ST_CHILD_CHK;
			ST_CHILD_CHK: begin
				state_d = (!phase_q && child_zero) ? ST_NODE_RD : ST_INFO_RD;
			end
			ST_INFO_RD:  state_d = ST_INFO_CHK;
			ST_INFO_CHK: state_d = ST_DONE;
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			pos_q   <= '0;
			total_q <= NW'(ROOT_ODD);
			last_q  <= NW'(ROOT_EVEN);
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + CAW'(1);
				ST_IDLE: begin
					if (in_valid) begin
						phase_q <= 1'b0;
					end
				end
				ST_CHILD_CHK: begin
					if (!phase_q && child_zero) begin
						phase_q <= 1'b1;
					end
				end
				ST_INFO_CHK: begin
					pos_q <= pos_q + PW'(1);
					if (phase_q) begin
						total_q <= new_idx;
						last_q  <= new_idx;
					end else begin
						last_q <= tgt_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ch_q  <= ch_sat;
					u_q   <= last_q;
					res_q <= '{overflow: 1'b1, default: '0};
				end
			end
			ST_NODE_CHK: begin
				link_q <= cl;
				ulen_q <= clen;
				if (!u_odd && k_neg) begin
					u_q <= cl;
				end
			end
			ST_TEXT_CHK: begin
				if (!text_hit) begin
					u_q <= link_q;
				end
			end
			ST_CHILD_RD: begin
				if (!phase_q) begin
					plen_q   <= ulen_q;
					pcaddr_q <= caddr;
				end
			end
			ST_CHILD_CHK: begin
				tgt_q <= child_rdata;
				if (!phase_q && child_zero) begin
					u_q <= link_q;
				end
			end
			ST_INFO_CHK: begin
				if (phase_q) begin
					res_q <= '{node_index: OUT_W'(new_idx),
						pal_length: OUT_W'(new_len_w[PW-1:0]),
						suffix_pal_count: OUT_W'(new_cnt),
						created: 1'b1, overflow: 1'b0};
				end else begin
					res_q <= '{node_index: OUT_W'(tgt_q),
						pal_length: OUT_W'(nd_len),
						suffix_pal_count: OUT_W'(nd_cnt),
						created: 1'b0, overflow: 1'b0};
				end
			end
			default: ;
		endcase
	end

endmodule
